>>> hw/rtl/ttbc_pkg.sv
// shared types and constants of the tap tempo beat clock
`timescale 1ns / 1ps

package ttbc_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_TAP  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic [15:0] TEMPO_MAX   = 16'd38400;
  localparam logic [15:0] TEMPO_RESET = 16'd15360;
  localparam logic [31:0] TPM_RESET   = 32'd60000000;

  // sequencer loop bounds (index of the last step of each loop)
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MUL_LAST      = 7'd15;
  localparam logic [CNT_W-1:0] DIV_LAST      = 7'd63;
  localparam logic [CNT_W-1:0] DIV_LAST_LONG = 7'd79;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic finish;
    logic out_load;
    logic cfg_we;
  } cmd_t;

  typedef struct packed {
    logic need_math;
    logic long_div;
  } sts_t;

endpackage

>>> hw/rtl/ttbc_dpath.sv
// datapath: tempo state, tap ring, shared multiplier and divider, result register
`timescale 1ns / 1ps

module ttbc_dpath #(
  parameter int TAP_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  ttbc_pkg::cmd_t     cmd,
  output ttbc_pkg::sts_t     sts,
  input  logic [1:0]         operation,
  input  logic [19:0]        time_delta,
  input  logic [15:0]        tempo_value,
  input  logic [31:0]        cfg_data,
  output logic               beat,
  output logic [15:0]        phase,
  output logic [15:0]        tempo,
  output logic [31:0]        beat_total
);
  import ttbc_pkg::*;

  localparam int AW = $clog2(TAP_SLOTS);
  localparam int FW = $clog2(TAP_SLOTS + 1);
  localparam int SW = $clog2(2 * TAP_SLOTS + 1);

  logic [31:0]    tpm;
  logic [47:0]    elapsed;
  logic [47:0]    now;
  logic [15:0]    tempo_reg;
  logic [15:0]    phase_reg;
  logic [31:0]    beat_counter;
  logic [AW-1:0]  head;
  logic [FW-1:0]  fill;
  logic           beat_flag;

  logic [1:0]     op_q;
  logic [19:0]    delta_q;
  logic [15:0]    req_q;

  logic [47:0]    ring [TAP_SLOTS];
  logic [47:0]    oldest_rd;

  logic [47:0]    mul_a;
  logic [15:0]    mul_b;
  logic [47:0]    mul_a_q;
  logic [15:0]    mul_b_q;
  logic [63:0]    acc;
  logic [47:0]    divisor;
  logic [79:0]    dq;
  logic [47:0]    rem;

  logic [15:0]    nt;
  logic [38:0]    den;
  logic [47:0]    elapsed_tick;
  logic [FW-1:0]  fill_next;
  logic [AW-1:0]  head_next;
  logic [SW-1:0]  old_sum;
  logic [SW-1:0]  old_idx;
  logic [48:0]    shifted;
  logic [49:0]    trial;
  logic [63:0]    quo;

  assign nt           = (req_q > TEMPO_MAX) ? TEMPO_MAX : req_q;
  assign den          = {((tpm == 32'd0) ? 32'd1 : tpm), 7'd0};
  assign elapsed_tick = elapsed + 48'(delta_q);
  assign fill_next    = (fill == FW'(TAP_SLOTS)) ? fill : fill + FW'(1);
  assign head_next    = (head == AW'(TAP_SLOTS - 1)) ? '0 : head + AW'(1);
  // oldest slot after this write, wrapped once
  assign old_sum      = SW'(head) + SW'(1) + SW'(TAP_SLOTS) - SW'(fill_next);
  assign old_idx      = (old_sum >= SW'(TAP_SLOTS)) ? old_sum - SW'(TAP_SLOTS) : old_sum;
  assign shifted      = {rem, dq[79]};
  assign trial        = {1'b0, shifted} - {2'b0, divisor};
  assign quo          = dq[63:0];

  always_comb begin
    sts.long_div = (op_q == OP_TICK);
    unique case (op_q)
      OP_TICK: sts.need_math = (tempo_reg != 16'd0);
      OP_SET:  sts.need_math = (tempo_reg != 16'd0) && (nt != 16'd0);
      OP_TAP:  sts.need_math = (fill != '0);
      default: sts.need_math = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_TICK: begin
        mul_a = elapsed_tick;
        mul_b = tempo_reg;
      end
      OP_TAP: begin
        mul_a = {9'd0, den};
        mul_b = 16'(fill_next - FW'(1));
      end
      default: begin
        mul_a = elapsed;
        mul_b = tempo_reg;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm          <= TPM_RESET;
      elapsed      <= '0;
      now          <= '0;
      tempo_reg    <= TEMPO_RESET;
      phase_reg    <= '0;
      beat_counter <= '0;
      head         <= '0;
      fill         <= '0;
      beat_flag    <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        tpm <= cfg_data;
      end
      if (cmd.prep) begin
        beat_flag <= 1'b0;
        unique case (op_q)
          OP_TICK: begin
            now     <= now + 48'(delta_q);
            elapsed <= elapsed_tick;
            if (tempo_reg == 16'd0) begin
              phase_reg <= '0;
            end
          end
          OP_SET: begin
            if (tempo_reg == 16'd0 || nt == 16'd0) begin
              tempo_reg <= nt;
            end
          end
          OP_TAP: begin
            head <= head_next;
            fill <= fill_next;
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        unique case (op_q)
          OP_TICK: begin
            phase_reg <= dq[15:0];
            if (dq[15:0] < phase_reg) begin
              beat_flag    <= 1'b1;
              beat_counter <= beat_counter + 32'd1;
            end
          end
          OP_SET: begin
            elapsed   <= (|quo[63:48]) ? '1 : quo[47:0];
            tempo_reg <= nt;
          end
          OP_TAP: begin
            tempo_reg <= (quo > 64'(TEMPO_MAX)) ? TEMPO_MAX : quo[15:0];
            elapsed   <= '0;
            phase_reg <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // item latch, arithmetic and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      delta_q <= time_delta;
      req_q   <= tempo_value;
    end
    if (cmd.prep) begin
      acc <= '0;
      mul_a_q <= mul_a;
      mul_b_q <= mul_b;
    end
    if (cmd.mul_step) begin
      acc     <= {acc[62:0], 1'b0} + (mul_b_q[15] ? {16'd0, mul_a_q} : 64'd0);
      mul_b_q <= {mul_b_q[14:0], 1'b0};
    end
    if (cmd.div_load) begin
      dq  <= {acc, 16'd0};
      rem <= '0;
      unique case (op_q)
        OP_TICK: divisor <= {9'd0, den};
        OP_TAP:  divisor <= now - oldest_rd;
        default: divisor <= {32'd0, nt};
      endcase
    end
    if (cmd.div_step) begin
      if (!trial[49]) begin
        rem <= trial[47:0];
        dq  <= {dq[78:0], 1'b1};
      end else begin
        rem <= shifted[47:0];
        dq  <= {dq[78:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      beat       <= beat_flag;
      phase      <= phase_reg;
      tempo      <= tempo_reg;
      beat_total <= beat_counter;
    end
  end

  // tap ring: newest written at head, oldest read the same cycle
  always_ff @(posedge clk) begin
    if (cmd.prep && op_q == OP_TAP) begin
      ring[head] <= now;
      oldest_rd  <= ring[old_idx[AW-1:0]];
    end
  end

endmodule

>>> hw/rtl/ttbc_ctrl.sv
// controller: sequences accept, multiply, divide, update and result hand-off
`timescale 1ns / 1ps

module ttbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ttbc_pkg::sts_t     sts,
  output ttbc_pkg::cmd_t     cmd
);
  import ttbc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DLD  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_free;
  logic [CNT_W-1:0] div_last;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign div_last  = sts.long_div ? DIV_LAST_LONG : DIV_LAST;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    cmd.cfg_we = cfg_valid && cfg_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = sts.need_math ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == MUL_LAST) begin
          state_next = S_DLD;
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PREP))
    else $error("accepted beat not prepared");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == div_last) |=> (state == S_FIN))
    else $error("divide did not finish on its last step");

endmodule

>>> hw/rtl/tap_tempo_beat_clock_unit.sv
// top level of the tap tempo beat clock
`timescale 1ns / 1ps

// Tap tempo beat clock.
// Input channel (in_valid / in_stall): a beat carries operation, time_delta
// and tempo_value; it is taken at an edge with in_valid high and in_stall low.
// Operation tick advances time and recomputes the beat phase, tap records the
// current time and retimes the tempo from the mean tap interval, set loads a
// tempo clamped to 300 bpm while keeping the beat position.
// Output channel (out_valid / out_stall): one result beat per input beat with
// beat, phase, tempo and beat_total, held in a register until taken.
// Config channel (cfg_valid / cfg_ready): writes ticks_per_minute, taken only
// while no item is in flight.
// Work per beat: tick with nonzero tempo runs a 16-step shift-add multiply
// and an 80-step restoring divide; set with rescale and every tap after the
// first run the multiply and a 64-step divide; other beats skip both. The
// next beat can be taken in the cycle after the result is loaded, so
// one item at a time goes through the shared multiplier and divider.
// Reset (rst, synchronous) gives 120 bpm, zero time, phase and count, and an
// empty tap ring. A stalled receiver holds the result; the next input beat is
// still taken and worked on, then waits for the result register to free up.
module tap_tempo_beat_clock_unit #(
  parameter int TAP_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [19:0] time_delta,
  input  logic [15:0] tempo_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        beat,
  output logic [15:0] phase,
  output logic [15:0] tempo,
  output logic [31:0] beat_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ttbc_pkg::*;

  cmd_t cmd;  // controller commands
  sts_t sts;  // datapath status

  ttbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttbc_dpath #(
    .TAP_SLOTS (TAP_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .time_delta  (time_delta),
    .tempo_value (tempo_value),
    .cfg_data    (cfg_data),
    .beat        (beat),
    .phase       (phase),
    .tempo       (tempo),
    .beat_total  (beat_total)
  );

endmodule
